>>> hw/rtl/packed_bit_array_access_top_defines.svh
// Assertion macros shared by the packed bit array RTL.
`ifndef PACKED_BIT_ARRAY_ACCESS_TOP_DEFINES_SVH
`define PACKED_BIT_ARRAY_ACCESS_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is high.
`define PBA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, disabled while reset is high.
`define PBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PBA_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PBA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/pba_pkg.sv
// Types, constants and helper functions of the packed bit array.
package pba_pkg;

   // Cube geometry and entry widths.
   localparam int CUBE_SIDE   = 16;
   localparam int COORD_W     = 4;
   localparam int NUM_ENTRIES = CUBE_SIDE * CUBE_SIDE * CUBE_SIDE;
   localparam int INDEX_W     = $clog2(NUM_ENTRIES);
   localparam int MAX_WIDTH   = 16;
   localparam int WIDTH_W     = 5;
   localparam int VALUE_W     = 16;

   // Packed storage words.
   localparam int WORD_BITS   = 64;
   localparam int POS_W       = $clog2(WORD_BITS);
   localparam int NUM_WORDS   = (NUM_ENTRIES * MAX_WIDTH + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W      = $clog2(NUM_WORDS);
   localparam int BIT_OFS_W   = $clog2(NUM_ENTRIES * MAX_WIDTH);

   // Command queue between the front and back ends.
   localparam int QUEUE_DEPTH = 2;

   // Entry width after reset.
   localparam logic [WIDTH_W-1:0] RESET_WIDTH = WIDTH_W'(4);

   // Operation codes carried by each input word.
   typedef enum logic {
      ACT_READ  = 1'b0,
      ACT_WRITE = 1'b1
   } action_type;

   // One classified command as it travels from the front end to the back end.
   typedef struct packed {
      action_type           action;
      logic [ADDR_W-1:0]    word_idx;
      logic [POS_W-1:0]     pos;
      logic [WIDTH_W-1:0]   width;
      logic                 spans;
      logic [VALUE_W-1:0]   value;
   } pba_cmd_type;

   // Mask of the low width bits; width is already limited to 1..MAX_WIDTH.
   function automatic logic [VALUE_W-1:0] low_mask(input logic [WIDTH_W-1:0] width);
      logic [VALUE_W:0] ones;
      ones = ({{VALUE_W{1'b0}}, 1'b1} << width) - {{VALUE_W{1'b0}}, 1'b1};
      return ones[VALUE_W-1:0];
   endfunction

endpackage

>>> hw/rtl/pba_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module pba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/pba_front.sv
// Front end: accepts request words, holds the width register and classifies each access.
module pba_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic [pba_pkg::COORD_W-1:0]   req_coord_x,
   input  logic [pba_pkg::COORD_W-1:0]   req_coord_y,
   input  logic [pba_pkg::COORD_W-1:0]   req_coord_z,
   input  logic [pba_pkg::VALUE_W-1:0]   req_write_value,
   input  logic                          csr_wr_en,
   input  logic [pba_pkg::WIDTH_W-1:0]   csr_wr_data,
   input  logic                          clearing,
   input  logic                          queue_full,
   output logic                          push,
   output pba_pkg::pba_cmd_type          push_cmd
);
   import pba_pkg::*;

   logic [WIDTH_W-1:0]         entry_width_ff;
   logic [WIDTH_W-1:0]         entry_width_in;
   logic [WIDTH_W-1:0]         eff_width;
   logic [INDEX_W-1:0]         lin_index;
   logic [INDEX_W+WIDTH_W-1:0] product;
   logic [BIT_OFS_W-1:0]       bit_ofs;
   logic [POS_W:0]             end_pos;

   // Width register; the user writes it only while the block is idle; not enforced.
   always_comb begin
      entry_width_in = entry_width_ff;
      if (csr_wr_en) begin
         entry_width_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_width_ff <= RESET_WIDTH;
      end else begin
         entry_width_ff <= entry_width_in;
      end
   end

   // A width of zero acts as one, and widths above the maximum saturate.
   always_comb begin
      eff_width = entry_width_ff;
      if (entry_width_ff == '0) begin
         eff_width = WIDTH_W'(1);
      end else if (entry_width_ff > WIDTH_W'(MAX_WIDTH)) begin
         eff_width = WIDTH_W'(MAX_WIDTH);
      end
   end

   // Linear index is x + (y*side + z)*side; the side is a power of two.
   assign lin_index = {req_coord_y, req_coord_z, req_coord_x};
   assign product   = {{WIDTH_W{1'b0}}, lin_index} * {{INDEX_W{1'b0}}, eff_width};
   assign bit_ofs   = product[BIT_OFS_W-1:0];
   assign end_pos   = {1'b0, bit_ofs[POS_W-1:0]} + (POS_W+1)'(eff_width);

   // Classified command for the back end.
   always_comb begin
      push_cmd.action   = action_type'(req_action);
      push_cmd.word_idx = bit_ofs[BIT_OFS_W-1:POS_W];
      push_cmd.pos      = bit_ofs[POS_W-1:0];
      push_cmd.width    = eff_width;
      push_cmd.spans    = end_pos > (POS_W+1)'(WORD_BITS);
      push_cmd.value    = req_write_value & low_mask(eff_width);
   end

   // Hold off new words while the store is being cleared or the queue is full.
   assign req_stall = queue_full | clearing;
   assign push      = req_valid & ~req_stall;

endmodule

>>> hw/rtl/pba_queue.sv
// Short command queue between the front end and the back end.
`include "packed_bit_array_access_top_defines.svh"
module pba_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  pba_pkg::pba_cmd_type  push_cmd,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output pba_pkg::pba_cmd_type  head_cmd
);
   import pba_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   pba_cmd_type       slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   assign full     = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign head_cmd = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue slots carry payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `PBA_ASSERT_IMPLY(a_no_push_when_full, clock, reset, push, !full)
   `PBA_ASSERT_IMPLY(a_no_pop_when_empty, clock, reset, pop, !empty)
   `PBA_ASSERT_NEXT(a_push_fills, clock, reset, push && !pop, !empty)

endmodule

>>> hw/rtl/pba_back.sv
// Back end: clears the store after reset and carries out reads and read-modify-writes.
`include "packed_bit_array_access_top_defines.svh"
module pba_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          empty,
   input  pba_pkg::pba_cmd_type          head_cmd,
   output logic                          pop,
   output logic                          clearing,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pba_pkg::VALUE_W-1:0]   rsp_read_value
);
   import pba_pkg::*;

   localparam int PAIR_W = 2 * WORD_BITS;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_WORDS - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LO,
      ST_HI
   } state_type;

   state_type             state_ff;
   state_type             state_in;
   pba_cmd_type           cmd_ff;
   pba_cmd_type           cmd_in;
   logic [WORD_BITS-1:0]  lo_word_ff;
   logic [WORD_BITS-1:0]  lo_word_in;
   logic [ADDR_W-1:0]     clear_addr_ff;
   logic [ADDR_W-1:0]     clear_addr_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [VALUE_W-1:0]    rsp_value_ff;
   logic [VALUE_W-1:0]    rsp_value_in;

   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [WORD_BITS-1:0]  rd_data;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [WORD_BITS-1:0]  wr_data;

   logic                  rsp_free;
   logic [ADDR_W-1:0]     next_addr;
   logic [VALUE_W-1:0]    mask;
   logic [WORD_BITS-1:0]  lo_src;
   logic [PAIR_W-1:0]     pair;
   logic [PAIR_W-1:0]     pair_shifted;
   logic [PAIR_W-1:0]     ext_mask;
   logic [PAIR_W-1:0]     ext_value;
   logic [VALUE_W-1:0]    read_result;
   logic [WORD_BITS-1:0]  lo_new;
   logic [WORD_BITS-1:0]  hi_new;

   pba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NUM_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The result register is free when empty or being taken this cycle.
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign next_addr = cmd_ff.word_idx + ADDR_W'(1);
   assign mask      = low_mask(cmd_ff.width);

   // Entry extraction and insertion across the word pair. A non-spanning
   // entry lies wholly in the low word, so the high half is don't-care then.
   assign lo_src       = (state_ff == ST_HI) ? lo_word_ff : rd_data;
   assign pair         = {rd_data, lo_src};
   assign pair_shifted = pair >> cmd_ff.pos;
   assign read_result  = pair_shifted[VALUE_W-1:0] & mask;
   assign ext_mask     = {{(PAIR_W-VALUE_W){1'b0}}, mask} << cmd_ff.pos;
   assign ext_value    = {{(PAIR_W-VALUE_W){1'b0}}, cmd_ff.value} << cmd_ff.pos;
   assign lo_new = (lo_src & ~ext_mask[WORD_BITS-1:0]) | ext_value[WORD_BITS-1:0];
   assign hi_new = (rd_data & ~ext_mask[PAIR_W-1:WORD_BITS]) | ext_value[PAIR_W-1:WORD_BITS];

   // Sequencer: reads each word of the entry, writes back as soon as data returns.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      lo_word_in    = lo_word_ff;
      clear_addr_in = clear_addr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      pop           = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = next_addr;
      wr_en         = 1'b0;
      wr_addr       = cmd_ff.word_idx;
      wr_data       = lo_new;
      case (state_ff)
         ST_CLEAR: begin
            wr_en         = 1'b1;
            wr_addr       = clear_addr_ff;
            wr_data       = '0;
            clear_addr_in = clear_addr_ff + ADDR_W'(1);
            if (clear_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            rd_addr = head_cmd.word_idx;
            if (!empty && (head_cmd.action == ACT_WRITE || rsp_free)) begin
               pop      = 1'b1;
               rd_en    = 1'b1;
               cmd_in   = head_cmd;
               state_in = ST_LO;
            end
         end
         ST_LO: begin
            lo_word_in = rd_data;
            if (cmd_ff.action == ACT_WRITE) begin
               wr_en = 1'b1;
            end
            if (cmd_ff.spans) begin
               rd_en    = 1'b1;
               state_in = ST_HI;
            end else begin
               state_in = ST_IDLE;
               if (cmd_ff.action == ACT_READ) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = read_result;
               end
            end
         end
         ST_HI: begin
            state_in = ST_IDLE;
            wr_addr  = next_addr;
            wr_data  = hi_new;
            if (cmd_ff.action == ACT_WRITE) begin
               wr_en = 1'b1;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_value_in = read_result;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      lo_word_ff   <= lo_word_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign clearing       = state_ff == ST_CLEAR;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;

   `PBA_ASSERT_IMPLY(a_no_pop_in_clear, clock, reset, state_ff == ST_CLEAR, !pop)
   `PBA_ASSERT_NEXT(a_span_reads_high, clock, reset, state_ff == ST_LO && cmd_ff.spans, state_ff == ST_HI)
   `PBA_ASSERT_NEXT(a_read_gives_word, clock, reset, state_ff == ST_HI && cmd_ff.action == ACT_READ, rsp_valid_ff)

endmodule

>>> hw/rtl/packed_bit_array_access_top.sv
// Top level of the packed variable-width bit array.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  action, coord_x/y/z, write_value
//   rsp_      out        rsp_valid / rsp_stall  read_value (reads only)
//   csr_      in         csr_wr_en              entry_width
//
// Each access passes through the back end as a read issue and a low-word step, plus a
// high-word step when the entry spans two words; the steps follow from the single read
// port of the word store and the write-back that follows each read. Writes return no word.
// After reset a clearing pass zeroes all 1024 words of the store; req_stall is high
// meanwhile. A two-entry queue lets the front end keep accepting while the back
// end waits; a read leaves the queue only when the result register is free.
module packed_bit_array_access_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic [pba_pkg::COORD_W-1:0]   req_coord_x,
   input  logic [pba_pkg::COORD_W-1:0]   req_coord_y,
   input  logic [pba_pkg::COORD_W-1:0]   req_coord_z,
   input  logic [pba_pkg::VALUE_W-1:0]   req_write_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pba_pkg::VALUE_W-1:0]   rsp_read_value,
   input  logic                          csr_wr_en,
   input  logic [pba_pkg::WIDTH_W-1:0]   csr_wr_data
);
   import pba_pkg::*;

   logic         push;
   pba_cmd_type  push_cmd;
   logic         queue_full;
   logic         pop;
   logic         queue_empty;
   pba_cmd_type  head_cmd;
   logic         clearing;

   pba_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .req_write_value (req_write_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .clearing        (clearing),
      .queue_full      (queue_full),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   pba_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .head_cmd (head_cmd)
   );

   pba_back u_back (
      .clock          (clock),
      .reset          (reset),
      .empty          (queue_empty),
      .head_cmd       (head_cmd),
      .pop            (pop),
      .clearing       (clearing),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value)
   );

endmodule

>>> verif/testbench.sv
// Self-checking testbench of the packed variable-width bit array top level.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pba_pkg::*;

   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 7;
   localparam int DRAIN_CYCLES    = 16;
   localparam int QUIET_LIMIT     = 4000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_ITEMS     = 115;
   localparam int FLOOD_ITEMS     = 24;
   localparam int RECENT_DEPTH    = 32;
   localparam int NUM_PHASES      = 12;
   localparam int LAST_ENTRY      = NUM_ENTRIES - 1;

   // Entry widths per phase; the first phase runs with the width left by reset.
   localparam logic [WIDTH_W-1:0] PHASE_WIDTHS [NUM_PHASES] =
      '{5'd4, 5'd3, 5'd1, 5'd16, 5'd0, 5'd31, 5'd7, 5'd12, 5'd17, 5'd5, 5'd13, 5'd9};

   // Shadow copy of the packed store that predicts every read word.
   class packed_store_tracker;
      logic [WORD_BITS-1:0] shadow_words [NUM_WORDS];
      logic [WIDTH_W-1:0]   width_reg;
      logic [VALUE_W-1:0]   pending_reads [$];
      int unsigned          mismatch_count;

      function new();
         foreach (shadow_words[i]) shadow_words[i] = '0;
         width_reg      = RESET_WIDTH;
         mismatch_count = 0;
      endfunction

      function void set_width(input logic [WIDTH_W-1:0] width);
         width_reg = width;
      endfunction

      // Zero counts as one bit, and anything above the maximum saturates.
      function int unsigned effective_width();
         if (width_reg == 0) return 1;
         if (width_reg > MAX_WIDTH) return MAX_WIDTH;
         return width_reg;
      endfunction

      function int pending();
         return pending_reads.size();
      endfunction

      // Apply one accepted request word; a read queues the entry it must return.
      function void note_access(input action_type act, input logic [COORD_W-1:0] x,
                                input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                                input logic [VALUE_W-1:0] value);
         int unsigned w, lin, bit_ofs, wi, pos;
         logic [2*WORD_BITS-1:0] pair, mask;
         w       = effective_width();
         lin     = int'(x) + (int'(y) * CUBE_SIDE + int'(z)) * CUBE_SIDE;
         bit_ofs = lin * w;
         wi      = bit_ofs / WORD_BITS;
         pos     = bit_ofs % WORD_BITS;
         // The entry may run into the following word, so work on the pair.
         pair[WORD_BITS-1:0] = shadow_words[wi];
         pair[2*WORD_BITS-1:WORD_BITS] = (wi + 1 < NUM_WORDS) ? shadow_words[wi+1] : '0;
         mask = ({{(2*WORD_BITS-1){1'b0}}, 1'b1} << w) - 1;
         if (act == ACT_READ) begin
            pending_reads.push_back(VALUE_W'((pair >> pos) & mask));
         end else begin
            pair = (pair & ~(mask << pos)) | (((2*WORD_BITS)'(value) & mask) << pos);
            shadow_words[wi] = pair[WORD_BITS-1:0];
            if (wi + 1 < NUM_WORDS) shadow_words[wi+1] = pair[2*WORD_BITS-1:WORD_BITS];
         end
      endfunction

      // Compare one accepted response word with the oldest predicted read.
      function void check_read(input logic [VALUE_W-1:0] seen);
         logic [VALUE_W-1:0] wanted;
         if (pending_reads.size() == 0) begin
            $error("read_value: no read pending, actual %h", seen);
            mismatch_count++;
            return;
         end
         wanted = pending_reads.pop_front();
         if (seen !== wanted) begin
            $error("read_value mismatch: expected %h, actual %h", wanted, seen);
            mismatch_count++;
         end
      endfunction
   endclass

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_stall;
   logic                req_action      = 1'b0;
   logic [COORD_W-1:0]  req_coord_x     = '0;
   logic [COORD_W-1:0]  req_coord_y     = '0;
   logic [COORD_W-1:0]  req_coord_z     = '0;
   logic [VALUE_W-1:0]  req_write_value = '0;
   logic                rsp_valid;
   logic                rsp_stall       = 1'b0;
   logic [VALUE_W-1:0]  rsp_read_value;
   logic                csr_wr_en       = 1'b0;
   logic [WIDTH_W-1:0]  csr_wr_data     = '0;

   packed_store_tracker book;
   bit                  hold_off_pending = 1'b0;
   int unsigned         calm_left        = 0;
   int                  recent_writes [$];

   packed_bit_array_access_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_value  (rsp_read_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Observe both channels at the rising edge and feed the tracker.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) book.check_read(rsp_read_value);
         if (req_valid && !req_stall) begin
            book.note_access(action_type'(req_action), req_coord_x, req_coord_y,
                             req_coord_z, req_write_value);
         end
      end
   end

   // End the run when no word moves on either channel for too long.
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $error("no word accepted for %0d cycles", QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   // Response side: random stall bursts and free-running stretches, plus one long hold.
   initial begin : response_side
      int unsigned stall_left, run_left, pick;
      stall_left = 0;
      run_left   = 0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            stall_left       = HOLD_OFF_CYCLES;
            run_left         = 0;
         end
         if (stall_left == 0 && run_left == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) stall_left = 0;
            else if (pick < 85) stall_left = $urandom_range(1, 3);
            else if (pick < 97) stall_left = $urandom_range(4, 10);
            else stall_left = $urandom_range(20, 60);
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(1, 4);
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            run_left--;
         end
      end
   end

   // Idle cycles before the next request word: mostly none, sometimes long.
   function automatic int unsigned pick_gap();
      int unsigned pick;
      if (calm_left != 0) begin
         calm_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   // First entry of the cube that crosses a word boundary, or -1 if none does.
   function automatic int first_spanning_entry(input int unsigned w);
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if ((i * w) % WORD_BITS + w > WORD_BITS) return i;
      end
      return -1;
   endfunction

   // Offer one request word after the given gap and hold it until it is accepted.
   task automatic send_word(input action_type act, input logic [11:0] lin,
                            input logic [VALUE_W-1:0] value, input int unsigned gap);
      repeat (gap) begin
         @(negedge clock);
         req_valid       <= 1'b0;
         req_action      <= 1'($urandom);
         req_coord_x     <= COORD_W'($urandom);
         req_coord_y     <= COORD_W'($urandom);
         req_coord_z     <= COORD_W'($urandom);
         req_write_value <= VALUE_W'($urandom);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_action      <= act;
      req_coord_x     <= lin[3:0];
      req_coord_z     <= lin[7:4];
      req_coord_y     <= lin[11:8];
      req_write_value <= value;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop offering, wait for every predicted read, then let writes finish.
   task automatic wait_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic settle_and_set_width(input logic [WIDTH_W-1:0] width);
      wait_until_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= width;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      book.set_width(width);
   endtask

   // Write an entry that straddles two words and its upper neighbor, then read back the entry and both neighbors.
   task automatic check_spanning_entry();
      int idx;
      idx = first_spanning_entry(book.effective_width());
      if (idx > 0) begin
         send_word(ACT_WRITE, 12'(idx), VALUE_W'($urandom), 0);
         send_word(ACT_WRITE, 12'(idx + 1), 16'hFFFF, 0);
         send_word(ACT_READ, 12'(idx), '0, 0);
         send_word(ACT_READ, 12'(idx - 1), '0, 0);
         send_word(ACT_READ, 12'(idx + 1), '0, 0);
      end
   endtask

   // Random traffic that in part revisits recently written entries and their neighbors.
   task automatic random_words(input int count);
      int unsigned pick;
      int lin;
      action_type act;
      logic [VALUE_W-1:0] value;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 45 && recent_writes.size() != 0) begin
            lin = recent_writes[$urandom_range(0, recent_writes.size() - 1)];
            lin = (lin + NUM_ENTRIES + int'($urandom_range(0, 2)) - 1) % NUM_ENTRIES;
         end else begin
            lin = $urandom_range(0, LAST_ENTRY);
         end
         act  = ($urandom_range(0, 1) != 0) ? ACT_WRITE : ACT_READ;
         pick = $urandom_range(0, 99);
         if (pick < 10) value = 16'hFFFF;
         else if (pick < 15) value = '0;
         else value = VALUE_W'($urandom);
         if (act == ACT_WRITE) begin
            recent_writes.push_back(lin);
            if (recent_writes.size() > RECENT_DEPTH) void'(recent_writes.pop_front());
         end
         send_word(act, 12'(lin), value, pick_gap());
      end
   endtask

   // Reset, then one phase per entry width.
   initial begin : stimulus
      book = new();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p != 0) settle_and_set_width(PHASE_WIDTHS[p]);
         if (p == 0) begin
            // Corners of the cube: cleared on reset, then all ones and all zeros.
            send_word(ACT_READ, 12'(0), '0, 0);
            send_word(ACT_READ, 12'(LAST_ENTRY), '0, 0);
            send_word(ACT_WRITE, 12'(0), 16'hFFFF, 0);
            send_word(ACT_WRITE, 12'(LAST_ENTRY), 16'hFFFF, 0);
            send_word(ACT_WRITE, 12'(1), 16'h0000, 0);
            send_word(ACT_READ, 12'(0), '0, 0);
            send_word(ACT_READ, 12'(1), '0, 0);
            send_word(ACT_READ, 12'(LAST_ENTRY), '0, 0);
            send_word(ACT_WRITE, 12'(LAST_ENTRY), 16'h0000, 0);
            send_word(ACT_READ, 12'(LAST_ENTRY), '0, 0);
         end
         check_spanning_entry();
         if (p == 2) begin
            // Hold the response side off while reads keep coming back to back.
            hold_off_pending = 1'b1;
            repeat (FLOOD_ITEMS) begin
               send_word(ACT_READ, 12'($urandom_range(0, LAST_ENTRY)), VALUE_W'($urandom), 0);
            end
         end
         random_words(PHASE_ITEMS);
      end
      wait_until_drained();
      if (book.mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
